// ----- src/sssd_pkg.sv -----
// Shared types and constants for the seven-segment scan driver.
package sssd_pkg;

  // Number of digit slots that are stored and scanned.
  localparam int unsigned SLOT_COUNT = 6;
  // Slots below this index go to segment bank 0, the rest to bank 1.
  localparam int unsigned BANK_SPLIT = 3;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);

  // Request action codes.
  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_BLANK = 2'd2
  } action_t;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] seg_t;

  localparam seg_t DOT_BIT    = 8'h80;
  localparam seg_t SELECT_OFF = 8'hFF;

  // Segment pattern (a..g on bits 0..6) for a decimal digit.
  function automatic seg_t seg_pattern(input digit_t d);
    seg_t p;
    begin
      case (d)
        4'd0:    p = 8'h3F;
        4'd1:    p = 8'h06;
        4'd2:    p = 8'h5B;
        4'd3:    p = 8'h4F;
        4'd4:    p = 8'h66;
        4'd5:    p = 8'h6D;
        4'd6:    p = 8'h7D;
        4'd7:    p = 8'h07;
        4'd8:    p = 8'h7F;
        4'd9:    p = 8'h6F;
        default: p = 8'h00;
      endcase
      return p;
    end
  endfunction

endpackage

// ----- src/seven_segment_scan_driver_unit.sv -----
// Top level of the multiplexed seven-segment scan driver.
//
// The block takes requests on the input channel (in_valid/in_ready) and
// delivers results on the output channel (out_valid/out_ready). A set
// request splits first_value and second_value into their hundreds, tens and
// units digits for slots 0-2 and 3-5 and marks up to two decimal points;
// it gives no result. A tick request drives one slot: the active-low
// one-hot digit select, the segment byte with the dot on bit 7 and the
// segment bank, then steps the slot counter modulo six. A blank request
// gives select 0xFF and segments 0. Action code 3 is dropped.
//
// A request is captured in an input register and is applied from there:
// it updates the stored digits and loads the result register, a tick or
// blank waiting there until the result register is free. One request
// per cycle is accepted while results are taken; the figure is set by the
// single pass through digit split and segment lookup between those registers.
// When the receiver stalls, the result register holds and the input
// register fills; after that in_ready drops until the result is taken.
// Synchronous reset clears all digits and dots to zero, the slot counter
// to slot 0 and empties both registers.
module seven_segment_scan_driver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] first_value,
  input  logic [15:0] second_value,
  input  logic [2:0]  first_dot,
  input  logic [2:0]  second_dot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  digit_select,
  output logic [7:0]  segments,
  output logic        bank
);
  import sssd_pkg::*;

  // Input register.
  logic        s1_valid;
  logic [1:0]  s1_action;
  logic [15:0] s1_first;
  logic [15:0] s1_second;
  logic [2:0]  s1_first_dot;
  logic [2:0]  s1_second_dot;

  // Display state.
  digit_t                 slot_digits [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  slot_dots;
  logic [SLOT_W-1:0]      scan_position;
  logic [SLOT_W-1:0]      scan_position_next;

  logic s1_has_result;
  logic s1_fire;
  logic out_free;
  logic is_set;
  logic is_tick;
  logic is_blank;

  logic [11:0]           first_digits;
  logic [11:0]           second_digits;
  logic [SLOT_COUNT-1:0] dots_next;
  seg_t                  tick_segments;
  seg_t                  tick_select;

  // Split the low three decimal digits of a 16-bit value using reciprocal
  // multiplies; each quotient is exact over the whole 16-bit range.
  function automatic logic [11:0] split_digits(input logic [15:0] v);
    logic [35:0] p10;
    logic [32:0] p100;
    logic [32:0] p1000;
    logic [15:0] q10;
    logic [15:0] q100;
    logic [15:0] q1000;
    logic [15:0] units;
    logic [15:0] tens;
    logic [15:0] hundreds;
    begin
      p10      = 36'(v) * 36'd52429;
      p100     = 33'(v) * 33'd83887;
      p1000    = 33'(v) * 33'd67109;
      q10      = 16'(p10[34:19]);
      q100     = 16'(p100[32:23]);
      q1000    = 16'(p1000[32:26]);
      units    = v - ((q10 << 3) + (q10 << 1));
      tens     = q10 - ((q100 << 3) + (q100 << 1));
      hundreds = q100 - ((q1000 << 3) + (q1000 << 1));
      return {hundreds[3:0], tens[3:0], units[3:0]};
    end
  endfunction

  always_comb begin
    is_set   = 1'b0;
    is_tick  = 1'b0;
    is_blank = 1'b0;
    case (s1_action)
      ACT_SET:   is_set   = 1'b1;
      ACT_TICK:  is_tick  = 1'b1;
      ACT_BLANK: is_blank = 1'b1;
      default: begin
      end
    endcase
  end

  // A request that gives no result never waits on the output side.
  assign s1_has_result = is_tick || is_blank;
  assign out_free      = !out_valid || out_ready;
  assign s1_fire       = s1_valid && (!s1_has_result || out_free);
  assign in_ready      = !s1_valid || s1_fire;

  assign first_digits  = split_digits(s1_first);
  assign second_digits = split_digits(s1_second);

  // A dot position outside the scanned slots marks nothing.
  always_comb begin
    dots_next = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if ((32'(s1_first_dot) == i) || (32'(s1_second_dot) == i)) begin
        dots_next[i] = 1'b1;
      end
    end
  end

  always_comb begin
    tick_segments = seg_pattern(slot_digits[scan_position]);
    if (slot_dots[scan_position]) begin
      tick_segments = tick_segments | DOT_BIT;
    end
    tick_select = ~(8'd1 << scan_position);
    if (32'(scan_position) == SLOT_COUNT - 1) begin
      scan_position_next = '0;
    end else begin
      scan_position_next = scan_position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action     <= action;
      s1_first      <= first_value;
      s1_second     <= second_value;
      s1_first_dot  <= first_dot;
      s1_second_dot <= second_dot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_digits[i] <= '0;
      end
      slot_dots     <= '0;
      scan_position <= '0;
    end else if (s1_fire) begin
      if (is_set) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (i < 3) begin
            slot_digits[i] <= first_digits[(2 - i) * 4 +: 4];
          end else if (i < 6) begin
            slot_digits[i] <= second_digits[(5 - i) * 4 +: 4];
          end else begin
            slot_digits[i] <= '0;
          end
        end
        slot_dots <= dots_next;
      end else if (is_tick) begin
        scan_position <= scan_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_result) begin
      if (is_tick) begin
        digit_select <= tick_select;
        segments     <= tick_segments;
        bank         <= (32'(scan_position) >= BANK_SPLIT);
      end else begin
        digit_select <= SELECT_OFF;
        segments     <= '0;
        bank         <= 1'b0;
      end
    end
  end

  // The slot counter never leaves the scanned range.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    32'(scan_position) < SLOT_COUNT)
    else $error("scan position out of range");

  // A driven slot enables exactly one digit.
  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (digit_select != SELECT_OFF) |-> $countones(~digit_select) == 1)
    else $error("digit select is not one-hot");

  // A blanked result carries no segments and bank 0.
  a_blank_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && (digit_select == SELECT_OFF) |-> (segments == '0) && !bank)
    else $error("blank result drives segments");

  // A tick or blank request that leaves the input register shows a result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_has_result |=> out_valid)
    else $error("result lost");

  // A set request moves no scan position.
  a_set_keeps_scan: assert property (@(posedge clk) disable iff (rst)
    s1_fire && is_set |=> $stable(scan_position))
    else $error("set request moved the scan position");

endmodule

// ----- tb/sv/scan_display_checker.sv -----
// Checker for the seven-segment scan driver: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module scan_display_checker
  import sssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] first_value,
  input  logic [15:0] second_value,
  input  logic [2:0]  first_dot,
  input  logic [2:0]  second_dot,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  digit_select,
  input  logic [7:0]  segments,
  input  logic        bank,
  output int unsigned mismatches,
  output int unsigned awaited
);

  typedef struct packed {
    logic [7:0] select;
    seg_t       segs;
    logic       bank;
  } scan_frame_t;

  // Glyphs for digits 0..9, digit 0 in the low byte.
  localparam logic [79:0] GLYPHS = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  digit_t      shown_digit [0:7];
  logic        shown_dot   [0:7];
  logic [2:0]  scan_slot;
  scan_frame_t frames_due  [$];

  task automatic clear_display();
    int i;
    begin
      for (i = 0; i < 8; i++) begin
        shown_digit[i] = '0;
        shown_dot[i]   = 1'b0;
      end
    end
  endtask

  task automatic load_display(input logic [15:0] v0, input logic [15:0] v1,
                              input logic [2:0] d0, input logic [2:0] d1);
    int unsigned a;
    int unsigned b;
    begin
      a = v0;
      b = v1;
      clear_display();
      shown_digit[0] = digit_t'((a / 100) % 10);
      shown_digit[1] = digit_t'((a / 10) % 10);
      shown_digit[2] = digit_t'(a % 10);
      shown_digit[3] = digit_t'((b / 100) % 10);
      shown_digit[4] = digit_t'((b / 10) % 10);
      shown_digit[5] = digit_t'(b % 10);
      // A dot position past the last slot marks nothing.
      if (d0 < SLOT_COUNT) shown_dot[d0] = 1'b1;
      if (d1 < SLOT_COUNT) shown_dot[d1] = 1'b1;
    end
  endtask

  task automatic scan_tick(output scan_frame_t f);
    seg_t glyph;
    int   d;
    begin
      d = shown_digit[scan_slot];
      glyph = (d < 10) ? GLYPHS[8*d +: 8] : '0;
      if (shown_dot[scan_slot]) glyph = glyph | DOT_BIT;
      f.select = ~(8'd1 << scan_slot);
      f.segs   = glyph;
      f.bank   = (scan_slot >= BANK_SPLIT);
      scan_slot = (scan_slot + 1 >= SLOT_COUNT) ? 3'd0 : scan_slot + 3'd1;
    end
  endtask

  always @(posedge clk) begin : watch
    scan_frame_t want;
    scan_frame_t made;
    if (rst) begin
      clear_display();
      scan_slot = '0;
      frames_due.delete();
      mismatches = 0;
    end else begin
      // Results first: a request taken at this edge cannot be answered at it.
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: result with none expected: select %h segments %h bank %b",
                   $time, digit_select, segments, bank);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          if (digit_select !== want.select) begin
            $display("%0t: digit_select expected %h got %h", $time, want.select,
                     digit_select);
            mismatches++;
          end
          if (segments !== want.segs) begin
            $display("%0t: segments expected %h got %h", $time, want.segs, segments);
            mismatches++;
          end
          if (bank !== want.bank) begin
            $display("%0t: bank expected %b got %b", $time, want.bank, bank);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (action)
          ACT_SET: load_display(first_value, second_value, first_dot, second_dot);
          ACT_TICK: begin
            scan_tick(made);
            frames_due.push_back(made);
          end
          ACT_BLANK: begin
            made.select = SELECT_OFF;
            made.segs   = '0;
            made.bank   = 1'b0;
            frames_due.push_back(made);
          end
          default: ;
        endcase
      end
    end
    awaited <= frames_due.size();
  end

endmodule

// ----- tb/sv/tb_seven_segment_scan_driver_unit.sv -----
// Testbench top for the seven-segment scan driver: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 100ps

module tb_seven_segment_scan_driver_unit;
  import sssd_pkg::*;

  // Action code 3 has no meaning; the block must drop it without a result.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Number of random requests that actually do something (set, tick, blank).
  localparam int RANDOM_REQUESTS = 850;
  // The last stretch of requests runs with no idling on either side.
  localparam int CALM_TAIL       = 120;
  // Request index at which the receiver starts its long hold-off.
  localparam int HOLD_AT         = 300;
  localparam int HOLD_CYCLES     = 300;
  // Cycles with no handshake on either channel before the run is abandoned.
  // The longest legal quiet stretch is the hold-off above plus a few bursts.
  localparam int WATCHDOG_LIMIT  = 2000;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int DRAIN_CYCLES    = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_SET;
  logic [15:0] first_value = '0;
  logic [15:0] second_value = '0;
  logic [2:0]  first_dot = '0;
  logic [2:0]  second_dot = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  digit_select;
  logic [7:0]  segments;
  logic        bank;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned idle_cycles = 0;

  // Shared between the sender and the receiver: calm_phase switches idling off
  // on both sides, hold_req asks the receiver for a long hold-off.
  bit calm_phase = 1'b0;
  bit hold_req   = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  seven_segment_scan_driver_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .first_value  (first_value),
    .second_value (second_value),
    .first_dot    (first_dot),
    .second_dot   (second_dot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_select (digit_select),
    .segments     (segments),
    .bank         (bank)
  );

  scan_display_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .first_value  (first_value),
    .second_value (second_value),
    .first_dot    (first_dot),
    .second_dot   (second_dot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_select (digit_select),
    .segments     (segments),
    .bank         (bank),
    .mismatches   (mismatches),
    .awaited      (awaited)
  );

  // Offers one request and returns at the edge where it is accepted. Outside
  // a calm phase the sender sometimes drops valid for a burst of cycles first.
  // When there is no gap, valid simply stays high into the next request, so it
  // is never lowered and raised within one time step.
  task automatic send_req(input logic [1:0] act, input logic [15:0] v0,
                          input logic [15:0] v1, input logic [2:0] d0,
                          input logic [2:0] d1);
    int unsigned gap;
    begin
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid     <= 1'b1;
      action       <= act;
      first_value  <= v0;
      second_value <= v1;
      first_dot    <= d0;
      second_dot   <= d1;
      do @(posedge clk); while (!in_ready);
    end
  endtask

  // Values mostly stay under 1000 or span the whole 16-bit range, so that
  // both the plain three-digit case and the wrap to the low digits are common.
  function automatic logic [15:0] pick_value();
    begin
      if ($urandom_range(0, 2) == 0) return 16'($urandom_range(0, 999));
      return 16'($urandom_range(0, 65535));
    end
  endfunction

  // Receiver: random stall bursts, and a long hold-off on request while the sender
  // keeps offering requests, so both internal registers fill and in_ready
  // drops. In a calm phase out_ready stays high.
  initial begin : receiver
    int unsigned burst;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("seven_segment_scan_driver_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int          issued;
    int unsigned pick;
    logic [1:0]  act;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A tick straight after reset shows digit 0 on slot 0.
    send_req(ACT_TICK, 16'd0, 16'd0, 3'd0, 3'd0);
    send_req(ACT_BLANK, 16'd0, 16'd0, 3'd0, 3'd0);
    // Both dot positions out of range: no dot anywhere.
    send_req(ACT_SET, 16'd0, 16'd0, 3'd6, 3'd7);
    repeat (6) send_req(ACT_TICK, 16'd0, 16'd0, 3'd0, 3'd0);
    // Largest values show only their low three digits; both dots on one slot.
    send_req(ACT_SET, 16'hFFFF, 16'd999, 3'd5, 3'd5);
    // The unused action code must leave the display untouched.
    send_req(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7);
    repeat (3) send_req(ACT_TICK, 16'd0, 16'd0, 3'd0, 3'd0);
    // A set does not move the scan position; a blank keeps it as well.
    send_req(ACT_SET, 16'd123, 16'd456, 3'd0, 3'd3);
    send_req(ACT_TICK, 16'd0, 16'd0, 3'd0, 3'd0);
    send_req(ACT_BLANK, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7);
    repeat (3) send_req(ACT_TICK, 16'd0, 16'd0, 3'd0, 3'd0);
    send_req(ACT_SET, 16'd1000, 16'hFFFF, 3'd7, 3'd0);
    repeat (3) send_req(ACT_TICK, 16'd0, 16'd0, 3'd0, 3'd0);

    // Random part. Ticks dominate so that every stored pattern is scanned
    // out; sets refresh the content often, blanks and dropped codes mix in.
    issued = 0;
    while (issued < RANDOM_REQUESTS) begin
      calm_phase = (issued >= RANDOM_REQUESTS - CALM_TAIL) || ((issued / 100) % 3 == 2);
      if (issued == HOLD_AT) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 58) act = ACT_TICK;
      else if (pick < 80) act = ACT_SET;
      else if (pick < 93) act = ACT_BLANK;
      else act = ACT_UNUSED;
      send_req(act, pick_value(), pick_value(), 3'($urandom_range(0, 7)),
               3'($urandom_range(0, 7)));
      if (act != ACT_UNUSED) issued++;
    end
    in_valid <= 1'b0;

    // Wait for every expected result, then a little longer for strays.
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited == 0) begin
      $display("seven_segment_scan_driver_unit: match");
    end else begin
      $display("seven_segment_scan_driver_unit: mismatch");
    end
    $finish;
  end

endmodule
